### rtl/cdpx_pkg.sv
// Shared types, codes and constants for the discovery TLV field extractor.
`default_nettype none

package cdpx_pkg;

   localparam int DataWidth   = 8;
   localparam int IdWidth     = 16;
   localparam int KindWidth   = 2;
   localparam int OffsetWidth = 5;
   localparam int PhaseWidth  = 3;

   localparam logic [IdWidth-1:0] ProtoIdReset = 16'h2000;

   localparam logic [OffsetWidth-1:0] IdOffsetHi  = 5'd20;
   localparam logic [OffsetWidth-1:0] IdOffsetLo  = 5'd21;
   localparam logic [OffsetWidth-1:0] LastHdrByte = 5'd25;
   localparam logic [OffsetWidth-1:0] TlvStart    = 5'd26;
   localparam logic [IdWidth-1:0]     TlvHdrLen   = 16'd4;

   localparam logic [IdWidth-1:0] TypeDeviceId = 16'h0001;
   localparam logic [IdWidth-1:0] TypePortId   = 16'h0003;
   localparam logic [IdWidth-1:0] TypePlatform = 16'h0005;

   localparam logic [PhaseWidth-1:0] PH_HEADER  = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_TYPE_HI = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_TYPE_LO = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_LEN_HI  = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_LEN_LO  = 3'd4;
   localparam logic [PhaseWidth-1:0] PH_VALUE   = 3'd5;
   localparam logic [PhaseWidth-1:0] PH_STOPPED = 3'd6;

   localparam logic [KindWidth-1:0] KIND_MATCH    = 2'd0;
   localparam logic [KindWidth-1:0] KIND_DEVICE   = 2'd1;
   localparam logic [KindWidth-1:0] KIND_PORT     = 2'd2;
   localparam logic [KindWidth-1:0] KIND_PLATFORM = 2'd3;

   typedef struct packed {
      logic                 valid;
      logic [KindWidth-1:0] event_kind;
      logic [DataWidth-1:0] value_byte;
      logic                 field_end;
   } result_type;

   function automatic logic [KindWidth-1:0] kind_of(input logic [IdWidth-1:0] rec_type);
      logic [KindWidth-1:0] kind;
      kind = KIND_MATCH;
      if (rec_type == TypeDeviceId) begin
         kind = KIND_DEVICE;
      end else if (rec_type == TypePortId) begin
         kind = KIND_PORT;
      end else if (rec_type == TypePlatform) begin
         kind = KIND_PLATFORM;
      end
      return kind;
   endfunction

endpackage

`default_nettype wire

### rtl/cdpx_parser.sv
// Per-frame parse state and the single-byte step of the TLV walk.
`default_nettype none

module cdpx_parser
   import cdpx_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [DataWidth-1:0] data_byte,
   input  wire logic                 frame_last,
   input  wire logic [IdWidth-1:0]   proto_id,
   output result_type                result
);

   logic [OffsetWidth-1:0] offset_ff, offset_in;
   logic [PhaseWidth-1:0]  phase_ff, phase_in;
   logic [DataWidth-1:0]   proto_hi_ff, proto_hi_in;
   logic [IdWidth-1:0]     rec_type_ff, rec_type_in;
   logic [IdWidth-1:0]     remain_ff, remain_in;
   logic [IdWidth-1:0]     rec_len;
   logic [IdWidth-1:0]     remain_dec;
   logic [KindWidth-1:0]   kind;
   logic                   rec_done;

   assign rec_len    = {remain_ff[DataWidth-1:0], data_byte};
   assign remain_dec = remain_ff - 16'd1;
   assign rec_done   = (remain_dec == '0);
   assign kind       = kind_of(rec_type_ff);

   always_comb begin
      offset_in   = offset_ff;
      phase_in    = phase_ff;
      proto_hi_in = proto_hi_ff;
      rec_type_in = rec_type_ff;
      remain_in   = remain_ff;
      result      = '0;
      unique case (phase_ff)
         PH_HEADER: begin
            priority if (offset_ff == IdOffsetHi) begin
               proto_hi_in = data_byte;
            end else if (offset_ff == IdOffsetLo) begin
               if ({proto_hi_ff, data_byte} == proto_id) begin
                  result.valid      = 1'b1;
                  result.event_kind = KIND_MATCH;
               end else begin
                  phase_in = PH_STOPPED;
               end
            end else if (offset_ff >= LastHdrByte) begin
               phase_in = PH_TYPE_HI;
            end
         end
         PH_TYPE_HI: begin
            rec_type_in = {data_byte, 8'h00};
            phase_in    = PH_TYPE_LO;
         end
         PH_TYPE_LO: begin
            rec_type_in = {rec_type_ff[IdWidth-1:DataWidth], data_byte};
            phase_in    = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            remain_in = {8'h00, data_byte};
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            priority if (rec_len < TlvHdrLen) begin
               remain_in = '0;
               phase_in  = PH_STOPPED;
            end else if (rec_len == TlvHdrLen) begin
               remain_in = '0;
               phase_in  = PH_TYPE_HI;
            end else begin
               remain_in = rec_len - TlvHdrLen;
               phase_in  = PH_VALUE;
            end
         end
         PH_VALUE: begin
            remain_in = remain_dec;
            if (kind != KIND_MATCH) begin
               result.valid      = 1'b1;
               result.event_kind = kind;
               result.value_byte = data_byte;
               result.field_end  = rec_done | frame_last;
            end
            if (rec_done) begin
               phase_in = PH_TYPE_HI;
            end
         end
         default: begin
         end
      endcase
      if (offset_ff < TlvStart) begin
         offset_in = offset_ff + 5'd1;
      end
      if (frame_last) begin
         offset_in   = '0;
         phase_in    = PH_HEADER;
         proto_hi_in = '0;
         rec_type_in = '0;
         remain_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         phase_ff    <= PH_HEADER;
         proto_hi_ff <= '0;
         rec_type_ff <= '0;
         remain_ff   <= '0;
      end else if (step) begin
         offset_ff   <= offset_in;
         phase_ff    <= phase_in;
         proto_hi_ff <= proto_hi_in;
         rec_type_ff <= rec_type_in;
         remain_ff   <= remain_in;
      end
   end

`ifndef ASSERT_OFF
   a_offset_sat: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= TlvStart)
      else $error("Frame offset ran past the start of the records.");
   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_STOPPED)
      else $error("Parse phase holds an unused code.");
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      step && frame_last |=> offset_ff == '0 && phase_ff == PH_HEADER)
      else $error("Parse state not cleared after the last byte of a frame.");
   a_value_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_VALUE |-> remain_ff != '0)
      else $error("Value phase entered with no value bytes left.");
`endif

endmodule

`default_nettype wire

### rtl/cdp_tlv_field_extractor.sv
// Top level of the discovery TLV field extractor with input and result registers.
// Path: a byte passes from the input register through the parse step into the
// result register, from which its result is transferred.
// Throughput: one byte per cycle while the result register is free; the parse
// step is one short pass between the input register and the result register.
// Reset: synchronous, active high; clears both registers' valid flags, the parse
// state and sets the protocol id register to 0x2000.
`default_nettype none

module cdp_tlv_field_extractor
   import cdpx_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [DataWidth-1:0] req_tdata,  // [7:0] data_byte
   input  wire logic                 req_tlast,  // frame_last
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [DataWidth-1:0]      rsp_tdata,  // [7:0] value_byte
   output logic [KindWidth-1:0]      rsp_tuser,  // [1:0] event_kind
   output logic                      rsp_tlast,  // field_end
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [IdWidth-1:0]   csr_data    // [15:0] cdp_protocol_id
);

   logic                 in_valid_ff;
   logic [DataWidth-1:0] in_byte_ff;
   logic                 in_last_ff;
   logic                 out_valid_ff;
   logic [DataWidth-1:0] out_byte_ff;
   logic [KindWidth-1:0] out_kind_ff;
   logic                 out_end_ff;
   logic [IdWidth-1:0]   proto_id_ff;
   logic                 out_free;
   logic                 advance;
   result_type           result;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   cdpx_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .frame_last (in_last_ff),
      .proto_id   (proto_id_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         proto_id_ff <= ProtoIdReset;
      end else if (csr_valid && csr_ready) begin
         proto_id_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && advance && result.valid) begin
         out_byte_ff <= result.value_byte;
         out_kind_ff <= result.event_kind;
         out_end_ff  <= result.field_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_end_ff;

`ifndef ASSERT_OFF
   a_match_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_MATCH |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("Match event carries a value byte or an end mark.");
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("Input register dropped a byte while the result side stalled.");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !in_valid_ff)
      else $error("Valid flags not cleared by reset.");
`endif

endmodule

`default_nettype wire
